// File: src/slpe_pkg.sv
package slpe_pkg;

    localparam int ModeW = 4;
    localparam int CfgW  = 16;
    localparam int TimeW = 32;
    localparam int FadeW = 8;

    localparam logic [ModeW-1:0] MODE_OFF    = 4'd0;
    localparam logic [ModeW-1:0] MODE_SLOW   = 4'd1;
    localparam logic [ModeW-1:0] MODE_FAST   = 4'd2;
    localparam logic [ModeW-1:0] MODE_VFAST  = 4'd3;
    localparam logic [ModeW-1:0] MODE_FADE   = 4'd4;
    localparam logic [ModeW-1:0] MODE_LOW    = 4'd5;
    localparam logic [ModeW-1:0] MODE_NORMAL = 4'd6;
    localparam logic [ModeW-1:0] MODE_BRIGHT = 4'd7;
    localparam logic [ModeW-1:0] MODE_PING   = 4'd8;

    localparam logic CMD_SERVICE = 1'b0;
    localparam logic CMD_SET     = 1'b1;

    localparam logic [FadeW-1:0] FADE_STEP_COUNT = 8'd16;

    localparam logic [2:0] CFG_SLOW_BLINK   = 3'd0;
    localparam logic [2:0] CFG_FAST_BLINK   = 3'd1;
    localparam logic [2:0] CFG_VFAST_BLINK  = 3'd2;
    localparam logic [2:0] CFG_FADE_STEP    = 3'd3;
    localparam logic [2:0] CFG_PING_INTERVAL = 3'd4;
    localparam logic [2:0] CFG_PING_LENGTH  = 3'd5;
    localparam logic [2:0] CFG_INIT_BRIGHT  = 3'd6;
    localparam logic [2:0] CFG_ERROR_BRIGHT = 3'd7;

    typedef struct packed {
        logic [CfgW-1:0] slow_blink_period;
        logic [CfgW-1:0] fast_blink_period;
        logic [CfgW-1:0] very_fast_blink_period;
        logic [CfgW-1:0] fade_step_interval;
        logic [CfgW-1:0] ping_interval;
        logic [CfgW-1:0] ping_length;
        logic [CfgW-1:0] init_bright_length;
        logic [CfgW-1:0] error_bright_length;
    } cfg_t;

    typedef struct packed {
        logic             command;
        logic [TimeW-1:0] now_time;
        logic [ModeW-1:0] new_mode;
        logic             init_flag;
        logic             error_flag;
    } item_t;

    function automatic logic [CfgW-1:0] half_period(input cfg_t cfg, input logic [ModeW-1:0] m);
        logic [CfgW-1:0] p;
        begin
            if (m == MODE_FAST)
                p = cfg.fast_blink_period;
            else if (m == MODE_VFAST)
                p = cfg.very_fast_blink_period;
            else
                p = cfg.slow_blink_period;
            return p;
        end
    endfunction

    // deadline reached when the wrapping difference is non-negative
    function automatic logic passed(input logic [TimeW-1:0] now, input logic [TimeW-1:0] dl);
        logic [TimeW-1:0] diff;
        begin
            diff = now - dl;
            return ~diff[TimeW-1];
        end
    endfunction

    function automatic logic [TimeW-1:0] arm(input logic [TimeW-1:0] now,
                                             input logic [CfgW-1:0] len);
        begin
            return now + {{(TimeW-CfgW){1'b0}}, len};
        end
    endfunction

endpackage

// File: src/status_led_pattern_engine.sv
// Status LED pattern engine. Each input beat carries a millisecond timestamp and
// a command: set-mode beats load a mode and give no result, service beats apply
// the init/error flags, run the mode handler and return one led_on beat. A beat
// is held in the input register, then the mode state and the result register
// update together; one beat is taken every cycle unless the input stalls, and
// its result is then presented from the result register. Only a service beat
// waiting behind a stalled result register holds back the input. Configuration
// writes take effect the cycle after the write enable.
module status_led_pattern_engine
    import slpe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [2:0]       cfg_index,
    input  logic [CfgW-1:0]  cfg_wdata,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic             command,
    input  logic [TimeW-1:0] now_time,
    input  logic [ModeW-1:0] new_mode,
    input  logic             init_flag,
    input  logic             error_flag,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             led_on
);

    cfg_t  cfg;
    item_t item_reg;
    logic  in_vld_reg;
    logic  out_vld_reg, out_vld_next;
    logic  led_reg, led_next;
    logic  out_free;
    logic  step;
    logic  led;

    slpe_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    slpe_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .step  (step),
        .item  (item_reg),
        .led   (led)
    );

    assign out_free = !out_vld_reg || !out_stall;
    // set beats never need the result register
    assign step     = in_vld_reg && (item_reg.command == CMD_SET || out_free);
    assign in_stall = in_vld_reg && !step;

    always_comb
    begin
        out_vld_next = out_vld_reg;
        led_next     = led_reg;
        if (out_free)
        begin
            out_vld_next = step && item_reg.command == CMD_SERVICE;
            led_next     = led;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
                in_vld_reg <= in_valid;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            item_reg.command    <= command;
            item_reg.now_time   <= now_time;
            item_reg.new_mode   <= new_mode;
            item_reg.init_flag  <= init_flag;
            item_reg.error_flag <= error_flag;
        end
        led_reg <= led_next;
    end

    assign out_valid = out_vld_reg;
    assign led_on    = led_reg;

    a_service_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        step && item_reg.command == CMD_SERVICE |=> out_valid)
        else $error("service beat produced no result");

    a_set_gives_none: assert property (@(posedge clk) disable iff (!rst_n)
        step && item_reg.command == CMD_SET && out_free |=> !out_valid)
        else $error("set beat produced a result");

    a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_vld_reg && out_vld_reg && out_stall)
        else $error("input stalled without a blocked result");

endmodule

// File: src/slpe_cfg_regs.sv
module slpe_cfg_regs
    import slpe_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  logic [2:0]      cfg_index,
    input  logic [CfgW-1:0] cfg_wdata,
    output cfg_t            cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slow_blink_period      <= 16'd500;
            cfg_reg.fast_blink_period      <= 16'd200;
            cfg_reg.very_fast_blink_period <= 16'd100;
            cfg_reg.fade_step_interval     <= 16'd20;
            cfg_reg.ping_interval          <= 16'd10000;
            cfg_reg.ping_length            <= 16'd50;
            cfg_reg.init_bright_length     <= 16'd100;
            cfg_reg.error_bright_length    <= 16'd500;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_SLOW_BLINK:    cfg_reg.slow_blink_period      <= cfg_wdata;
                CFG_FAST_BLINK:    cfg_reg.fast_blink_period      <= cfg_wdata;
                CFG_VFAST_BLINK:   cfg_reg.very_fast_blink_period <= cfg_wdata;
                CFG_FADE_STEP:     cfg_reg.fade_step_interval     <= cfg_wdata;
                CFG_PING_INTERVAL: cfg_reg.ping_interval          <= cfg_wdata;
                CFG_PING_LENGTH:   cfg_reg.ping_length            <= cfg_wdata;
                CFG_INIT_BRIGHT:   cfg_reg.init_bright_length     <= cfg_wdata;
                CFG_ERROR_BRIGHT:  cfg_reg.error_bright_length    <= cfg_wdata;
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/slpe_core.sv
module slpe_core
    import slpe_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    input  logic  step,
    input  item_t item,
    output logic  led
);

    logic [ModeW-1:0] mode_reg, mode_next;
    logic [ModeW-1:0] saved_reg, saved_next;
    logic             phase_reg, phase_next;
    logic [FadeW-1:0] fade_reg, fade_next;
    logic [TimeW-1:0] next_dl_reg, next_dl_next;
    logic [TimeW-1:0] ping_dl_reg, ping_dl_next;

    always_comb
    begin
        logic [FadeW-1:0] fade_inc;
        mode_next    = mode_reg;
        saved_next   = saved_reg;
        phase_next   = phase_reg;
        fade_next    = fade_reg;
        next_dl_next = next_dl_reg;
        ping_dl_next = ping_dl_reg;
        fade_inc     = fade_reg + 8'd1;
        led          = 1'b0;

        if (item.command == CMD_SET)
        begin
            mode_next  = item.new_mode;
            phase_next = 1'b0;
            if (item.new_mode inside {MODE_SLOW, MODE_FAST, MODE_VFAST})
                next_dl_next = arm(item.now_time, half_period(cfg, item.new_mode));
            else if (item.new_mode == MODE_FADE)
            begin
                fade_next    = '0;
                next_dl_next = arm(item.now_time, cfg.fade_step_interval);
            end
            else if (item.new_mode inside {MODE_LOW, MODE_NORMAL})
                ping_dl_next = arm(item.now_time, cfg.ping_interval);
        end
        else
        begin
            // init first, error second overwrites deadline and saves bright
            if (item.init_flag)
            begin
                saved_next   = mode_next;
                mode_next    = MODE_BRIGHT;
                next_dl_next = arm(item.now_time, cfg.init_bright_length);
                phase_next   = 1'b1;
            end
            if (item.error_flag)
            begin
                saved_next   = mode_next;
                mode_next    = MODE_BRIGHT;
                next_dl_next = arm(item.now_time, cfg.error_bright_length);
                phase_next   = 1'b1;
            end

            case (mode_next)
                MODE_SLOW, MODE_FAST, MODE_VFAST:
                begin
                    if (passed(item.now_time, next_dl_next))
                    begin
                        phase_next   = ~phase_next;
                        next_dl_next = arm(item.now_time, half_period(cfg, mode_next));
                    end
                    led = phase_next;
                end
                MODE_FADE:
                begin
                    if (passed(item.now_time, next_dl_next))
                    begin
                        fade_next    = fade_inc;
                        next_dl_next = arm(item.now_time, cfg.fade_step_interval);
                        if (fade_inc >= FADE_STEP_COUNT)
                        begin
                            mode_next    = saved_next;
                            ping_dl_next = arm(item.now_time, cfg.ping_interval);
                        end
                    end
                    led = (fade_next != '0);
                end
                MODE_LOW, MODE_NORMAL:
                begin
                    if (passed(item.now_time, ping_dl_next))
                    begin
                        saved_next   = mode_next;
                        mode_next    = MODE_PING;
                        next_dl_next = arm(item.now_time, cfg.ping_length);
                        phase_next   = 1'b1;
                    end
                    led = 1'b1;
                end
                MODE_BRIGHT, MODE_PING:
                begin
                    if (passed(item.now_time, next_dl_next))
                    begin
                        mode_next    = saved_next;
                        ping_dl_next = arm(item.now_time, cfg.ping_interval);
                    end
                    led = 1'b1;
                end
                default: led = 1'b0;   // off and undefined modes
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_OFF;
            saved_reg   <= MODE_OFF;
            phase_reg   <= 1'b0;
            fade_reg    <= '0;
            next_dl_reg <= '0;
            ping_dl_reg <= '0;
        end
        else if (step)
        begin
            mode_reg    <= mode_next;
            saved_reg   <= saved_next;
            phase_reg   <= phase_next;
            fade_reg    <= fade_next;
            next_dl_reg <= next_dl_next;
            ping_dl_reg <= ping_dl_next;
        end
    end

endmodule

// File: tb/sv/status_led_pattern_engine_tb.sv
module status_led_pattern_engine_tb;
    import slpe_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int SETTLE_CYCLES = 6;
    localparam int RESET_CYCLES  = 7;
    localparam logic [ModeW-1:0] MODE_LIMIT = 4'd9;
    localparam cfg_t DEFAULT_SETTINGS = {16'd500, 16'd200, 16'd100, 16'd20,
                                         16'd10000, 16'd50, 16'd100, 16'd500};

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [2:0]       cfg_index;
    logic [CfgW-1:0]  cfg_wdata;
    logic             in_valid;
    logic             in_stall;
    logic             command;
    logic [TimeW-1:0] now_time;
    logic [ModeW-1:0] new_mode;
    logic             init_flag;
    logic             error_flag;
    logic             out_valid;
    logic             out_stall;
    logic             led_on;

    status_led_pattern_engine dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .now_time   (now_time),
        .new_mode   (new_mode),
        .init_flag  (init_flag),
        .error_flag (error_flag),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .led_on     (led_on)
    );

    // LED model state
    cfg_t             led_cfg;
    logic [ModeW-1:0] led_mode;
    logic [ModeW-1:0] led_saved_mode;
    logic             led_phase;
    logic [FadeW-1:0] led_fade;
    logic [TimeW-1:0] led_next_dl;
    logic [TimeW-1:0] led_ping_dl;

    logic             led_expected[$];
    int               mismatch_count;
    int               cycle_count;
    bit               tx_quiet;
    bit               rx_quiet;
    logic [TimeW-1:0] t_now;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("status_led_pattern_engine_tb: FAIL");
            $finish;
        end
    end

    function automatic logic deadline_due(input logic [TimeW-1:0] now,
                                          input logic [TimeW-1:0] dl);
        logic [TimeW-1:0] d;
        d = now - dl;
        return ~d[TimeW-1];
    endfunction

    function automatic logic [TimeW-1:0] after_ms(input logic [TimeW-1:0] now,
                                                  input logic [CfgW-1:0] len);
        return now + {{(TimeW-CfgW){1'b0}}, len};
    endfunction

    function automatic logic [CfgW-1:0] blink_half(input logic [ModeW-1:0] m);
        logic [CfgW-1:0] p;
        case (m)
            MODE_FAST:  p = led_cfg.fast_blink_period;
            MODE_VFAST: p = led_cfg.very_fast_blink_period;
            default:    p = led_cfg.slow_blink_period;
        endcase
        return p;
    endfunction

    task automatic enter_bright(input logic [TimeW-1:0] now, input logic [CfgW-1:0] len);
        led_saved_mode = led_mode;
        led_mode       = MODE_BRIGHT;
        led_next_dl    = after_ms(now, len);
        led_phase      = 1'b1;
    endtask

    task automatic predict_led(input logic cmd, input logic [TimeW-1:0] now,
                               input logic [ModeW-1:0] nm, input logic fi, input logic fe);
        logic led;
        led = 1'b0;
        if (cmd == CMD_SET)
        begin
            led_mode  = nm;
            led_phase = 1'b0;
            if (nm == MODE_SLOW || nm == MODE_FAST || nm == MODE_VFAST)
                led_next_dl = after_ms(now, blink_half(nm));
            else if (nm == MODE_FADE)
            begin
                led_fade    = '0;
                led_next_dl = after_ms(now, led_cfg.fade_step_interval);
            end
            else if (nm == MODE_LOW || nm == MODE_NORMAL)
                led_ping_dl = after_ms(now, led_cfg.ping_interval);
        end
        else
        begin
            if (fi)
                enter_bright(now, led_cfg.init_bright_length);
            if (fe)
                enter_bright(now, led_cfg.error_bright_length);

            if (led_mode >= MODE_LIMIT || led_mode == MODE_OFF)
                led = 1'b0;
            else if (led_mode <= MODE_VFAST)
            begin
                if (deadline_due(now, led_next_dl))
                begin
                    led_phase   = ~led_phase;
                    led_next_dl = after_ms(now, blink_half(led_mode));
                end
                led = led_phase;
            end
            else if (led_mode == MODE_FADE)
            begin
                if (deadline_due(now, led_next_dl))
                begin
                    led_fade    = led_fade + 1'b1;
                    led_next_dl = after_ms(now, led_cfg.fade_step_interval);
                    if (led_fade >= FADE_STEP_COUNT)
                    begin
                        led_mode    = led_saved_mode;
                        led_ping_dl = after_ms(now, led_cfg.ping_interval);
                    end
                end
                led = (led_fade != '0);
            end
            else if (led_mode == MODE_LOW || led_mode == MODE_NORMAL)
            begin
                if (deadline_due(now, led_ping_dl))
                begin
                    led_saved_mode = led_mode;
                    led_mode       = MODE_PING;
                    led_next_dl    = after_ms(now, led_cfg.ping_length);
                    led_phase      = 1'b1;
                end
                led = 1'b1;
            end
            else
            begin
                // bright and ping fall back to the saved mode
                if (deadline_due(now, led_next_dl))
                begin
                    led_mode    = led_saved_mode;
                    led_ping_dl = after_ms(now, led_cfg.ping_interval);
                end
                led = 1'b1;
            end
            led_expected.push_back(led);
        end
    endtask

    task automatic send_beat(input logic cmd, input logic [TimeW-1:0] now,
                             input logic [ModeW-1:0] nm, input logic fi, input logic fe);
        int gap;
        command    <= cmd;
        now_time   <= now;
        new_mode   <= nm;
        init_flag  <= fi;
        error_flag <= fe;
        in_valid   <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        predict_led(cmd, now, nm, fi, fe);
        gap = tx_quiet ? 0 : $urandom_range(0, 16);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic service(input logic [TimeW-1:0] now, input logic fi, input logic fe);
        send_beat(CMD_SERVICE, now, MODE_OFF, fi, fe);
    endtask

    task automatic set_mode(input logic [TimeW-1:0] now, input logic [ModeW-1:0] nm);
        send_beat(CMD_SET, now, nm, 1'b0, 1'b0);
    endtask

    // hold the input side until every LED beat is back and the pipe is empty
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (led_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [CfgW-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic apply_settings(input cfg_t c);
        write_reg(CFG_SLOW_BLINK,    c.slow_blink_period);
        write_reg(CFG_FAST_BLINK,    c.fast_blink_period);
        write_reg(CFG_VFAST_BLINK,   c.very_fast_blink_period);
        write_reg(CFG_FADE_STEP,     c.fade_step_interval);
        write_reg(CFG_PING_INTERVAL, c.ping_interval);
        write_reg(CFG_PING_LENGTH,   c.ping_length);
        write_reg(CFG_INIT_BRIGHT,   c.init_bright_length);
        write_reg(CFG_ERROR_BRIGHT,  c.error_bright_length);
        cfg_wr_en <= 1'b0;
        led_cfg = c;
        @(posedge clk);
    endtask

    function automatic logic [CfgW-1:0] pick_len();
        if ($urandom_range(0, 1) == 0)
            return CfgW'($urandom_range(1, 200));
        return CfgW'($urandom_range(1, 65535));
    endfunction

    function automatic cfg_t rand_settings();
        cfg_t c;
        c.slow_blink_period      = pick_len();
        c.fast_blink_period      = pick_len();
        c.very_fast_blink_period = pick_len();
        c.fade_step_interval     = pick_len();
        c.ping_interval          = pick_len();
        c.ping_length            = pick_len();
        c.init_bright_length     = pick_len();
        c.error_bright_length    = pick_len();
        return c;
    endfunction

    function automatic logic [TimeW-1:0] step_span();
        logic [CfgW-1:0] hi;
        hi = led_cfg.slow_blink_period;
        if (led_cfg.fast_blink_period > hi)      hi = led_cfg.fast_blink_period;
        if (led_cfg.very_fast_blink_period > hi) hi = led_cfg.very_fast_blink_period;
        if (led_cfg.fade_step_interval > hi)     hi = led_cfg.fade_step_interval;
        if (led_cfg.ping_interval > hi)          hi = led_cfg.ping_interval;
        if (led_cfg.ping_length > hi)            hi = led_cfg.ping_length;
        if (led_cfg.init_bright_length > hi)     hi = led_cfg.init_bright_length;
        if (led_cfg.error_bright_length > hi)    hi = led_cfg.error_bright_length;
        return {16'd0, hi} * 2 + 4;
    endfunction

    // off mode, timed bright from each flag, both flags together, wrap of the deadline
    task automatic test_off_and_flags();
        service(32'd0, 1'b0, 1'b0);
        service(32'hFFFF_FFFF, 1'b1, 1'b0);
        service(32'd98, 1'b0, 1'b0);
        service(32'd99, 1'b0, 1'b0);
        service(32'd100, 1'b0, 1'b0);
        service(32'd200, 1'b1, 1'b1);
        service(32'd700, 1'b0, 1'b0);
        set_mode(32'd701, MODE_OFF);
        send_beat(CMD_SET, 32'd702, MODE_OFF, 1'b1, 1'b1);
        service(32'd703, 1'b0, 1'b0);
    endtask

    // each blink speed one tick before and exactly at its deadline
    task automatic test_blink_modes();
        logic [ModeW-1:0] m;
        logic [TimeW-1:0] base;
        for (m = MODE_SLOW; m <= MODE_VFAST; m++)
        begin
            base = 32'd1000 * m;
            set_mode(base, m);
            service(after_ms(base, blink_half(m)) - 1, 1'b0, 1'b0);
            service(after_ms(base, blink_half(m)), 1'b0, 1'b0);
        end
    endtask

    task automatic test_fade_start();
        set_mode(32'd5000, MODE_FADE);
        service(32'd5019, 1'b0, 1'b0);
        service(32'd5020, 1'b0, 1'b0);
    endtask

    // steady low, a deadline half the number space away, ping entry and return
    task automatic test_steady_ping();
        set_mode(32'd0, MODE_LOW);
        service(32'd10000 + 32'h8000_0000, 1'b0, 1'b0);
        service(32'd10000, 1'b0, 1'b0);
        service(32'd10050, 1'b0, 1'b0);
        set_mode(32'd20000, MODE_NORMAL);
        service(32'd30000, 1'b0, 1'b0);
    endtask

    // invalid mode survives a bright interval and returns dark
    task automatic test_invalid_mode();
        set_mode(32'd40000, 4'hF);
        service(32'd40001, 1'b0, 1'b1);
        service(32'd40501, 1'b0, 1'b0);
        service(32'd40502, 1'b0, 1'b0);
    endtask

    task automatic test_random_traffic(input int count);
        int               r;
        int               n;
        logic [TimeW-1:0] span;
        logic [ModeW-1:0] nm;
        span = step_span();
        for (n = 0; n < count; n++)
        begin
            if (n % 40 == 0)
            begin
                tx_quiet = ($urandom_range(0, 3) == 0);
                rx_quiet = ($urandom_range(0, 3) == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 25)
                t_now = t_now + $urandom_range(0, 3);
            else if (r < 85)
                t_now = t_now + $urandom_range(0, span);
            else if (r < 92)
                t_now = $urandom;
            else if (r < 96)
                t_now = t_now + 32'h7FFF_FFFF + $urandom_range(0, 2);
            else
                t_now = t_now - $urandom_range(0, span);

            if ($urandom_range(0, 99) < 15)
            begin
                if ($urandom_range(0, 99) < 85)
                    nm = ModeW'($urandom_range(MODE_OFF, MODE_PING));
                else
                    nm = ModeW'($urandom_range(MODE_LIMIT, 15));
                send_beat(CMD_SET, t_now, nm, 1'($urandom), 1'($urandom));
            end
            else
                send_beat(CMD_SERVICE, t_now, ModeW'($urandom),
                          ($urandom_range(0, 99) < 6), ($urandom_range(0, 99) < 6));

            if ($urandom_range(0, 99) < 2)
                drain_results();
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        drain_results();
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (led_expected.size() == 0)
            begin
                $error("led_on beat with nothing expected: got %0b", led_on);
                mismatch_count++;
            end
            else
            begin
                if (led_on !== led_expected[0])
                begin
                    $error("led_on mismatch: expected %0b, got %0b", led_expected[0], led_on);
                    mismatch_count++;
                end
                void'(led_expected.pop_front());
            end
        end
    end

    initial
    begin
        int k;
        out_stall = 1'b0;
        forever
        begin
            k = rx_quiet ? 0 : $urandom_range(0, 16);
            if (k != 0)
            begin
                out_stall <= 1'b1;
                repeat (k) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    initial
    begin
        cfg_t all_max;
        cfg_t all_min;
        cfg_t all_zero;
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = CFG_SLOW_BLINK;
        cfg_wdata      = '0;
        in_valid       = 1'b0;
        command        = CMD_SERVICE;
        now_time       = '0;
        new_mode       = MODE_OFF;
        init_flag      = 1'b0;
        error_flag     = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        tx_quiet       = 1'b0;
        rx_quiet       = 1'b0;
        t_now          = '0;
        led_cfg        = DEFAULT_SETTINGS;
        led_mode       = MODE_OFF;
        led_saved_mode = MODE_OFF;
        led_phase      = 1'b0;
        led_fade       = '0;
        led_next_dl    = '0;
        led_ping_dl    = '0;
        all_max        = '1;
        all_min        = {8{16'd1}};
        all_zero       = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_off_and_flags();
        test_blink_modes();
        test_fade_start();
        test_steady_ping();
        test_invalid_mode();
        drain_results();

        test_random_traffic(90);
        apply_settings(all_min);
        test_random_traffic(60);
        apply_settings(all_max);
        test_random_traffic(60);
        apply_settings(all_zero);
        test_random_traffic(40);
        repeat (3)
        begin
            apply_settings(rand_settings());
            test_random_traffic(60);
        end
        apply_settings(DEFAULT_SETTINGS);
        test_random_traffic(30);

        drain_results();
        if (mismatch_count == 0)
            $display("status_led_pattern_engine_tb: PASS");
        else
            $display("status_led_pattern_engine_tb: FAIL");
        $finish;
    end

endmodule

// File: filelist.f
src/slpe_pkg.sv
src/slpe_cfg_regs.sv
src/slpe_core.sv
src/status_led_pattern_engine.sv
tb/sv/status_led_pattern_engine_tb.sv
